[src/uniform_grid_binning_sort_top_defines.svh]
// Assertion macros shared by the grid binning sort checker.
`ifndef UNIFORM_GRID_BINNING_SORT_TOP_DEFINES_SVH
`define UNIFORM_GRID_BINNING_SORT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UGBS_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UGBS_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/ugbs_pkg.sv]
// Shared types and codes for the uniform grid binning sort block.
package ugbs_pkg;

	localparam int ACT_W = 3;
	localparam int STAT_W = 2;
	localparam int CS_W = 24;
	localparam int GRID_W = 7;
	localparam int CELL_RES_W = 12;
	localparam int RANGE_W = 11;
	localparam int PIDX_W = 10;
	localparam int COUNT_W = 11;
	localparam int QCELL_W = 12;
	localparam int QSLOT_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
	localparam logic [ACT_W-1:0] ACT_BUILD = 3'd1;
	localparam logic [ACT_W-1:0] ACT_RD_CELL = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RD_SLOT = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_OOR = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_W = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_H = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [CELL_RES_W-1:0] cell_res;
		logic [RANGE_W-1:0] range_start;
		logic [RANGE_W-1:0] range_end;
		logic [PIDX_W-1:0] point_index;
		logic [COUNT_W-1:0] point_count;
	} result_t;

endpackage

[src/ugbs_div.sv]
// Restoring divider, one quotient bit per cycle, shared by both axes.
module ugbs_div
	import ugbs_pkg::*;
#(
	parameter int PW = 24
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [PW-1:0] num,
	input logic [CS_W-1:0] den,
	output logic [PW-1:0] quot,
	output div_stat_t stat
);

	localparam int RW = ((PW > CS_W) ? PW : CS_W) + 1;
	localparam int CW = $clog2(PW);

	logic [PW-1:0] num_q;
	logic [CS_W-1:0] den_q;
	logic [RW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [RW-1:0] trial;
	logic take;

	assign trial = {rem_q[RW-2:0], num_q[PW-1]};
	assign take = (trial >= RW'(den_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(PW - 1);
				run_q <= 1'b1;
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath: shift the quotient into the numerator register
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= take ? (trial - RW'(den_q)) : trial;
			num_q <= {num_q[PW-2:0], take};
		end
	end

	assign quot = num_q;
	assign stat.busy = run_q;
	assign stat.done = done_q;

endmodule

[src/uniform_grid_binning_sort_top.sv]
// Uniform grid binning sort: point store, counting sort build and queries.
// Add runs two divisions, then locates the cell; read cell range / read sorted slot go
// through the query read state when answered from the stores, else answer at once; clear
// and unknown actions answer at once; build walks clear, count, prefix and scatter passes.
// One word at a time: busy stays high until the result strobe; done pulses one cycle.
// arst_n clears control, counters and flags, presets config; stores hold their data.
module uniform_grid_binning_sort_top
	import ugbs_pkg::*;
#(
	parameter int MAX_POINTS = 1024,
	parameter int MAX_CELLS = 4096,
	parameter int POS_WIDTH = 24
) (
	input logic clk,
	input logic arst_n,
	// command side
	input logic start,
	output logic busy,
	input logic [ACT_W-1:0] action,
	input logic signed [POS_WIDTH-1:0] pos_x,
	input logic signed [POS_WIDTH-1:0] pos_y,
	input logic [QCELL_W-1:0] query_cell,
	input logic [QSLOT_W-1:0] query_slot,
	// result side
	output logic done,
	output logic [STAT_W-1:0] status,
	output logic [CELL_RES_W-1:0] cell_res,
	output logic [RANGE_W-1:0] range_start,
	output logic [RANGE_W-1:0] range_end,
	output logic [PIDX_W-1:0] point_index,
	output logic [COUNT_W-1:0] point_count,
	// configuration write channel
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// point index, point count, cell index and cell count widths
	localparam int PIW = $clog2(MAX_POINTS);
	localparam int HW = $clog2(MAX_POINTS + 1);
	localparam int CIW = $clog2(MAX_CELLS);
	localparam int CTW = $clog2(MAX_CELLS + 1);
	localparam int PRW = 2 * GRID_W;
	localparam int NW = (CTW > PRW) ? CTW : PRW;
	localparam int QW = (HW > QSLOT_W) ? HW : QSLOT_W;

	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_DIVX  = 15'b000000000000010,
		S_DIVY  = 15'b000000000000100,
		S_LOC   = 15'b000000000001000,
		S_QRD   = 15'b000000000010000,
		S_CLR   = 15'b000000000100000,
		S_CNT_A = 15'b000000001000000,
		S_CNT_B = 15'b000000010000000,
		S_CNT_C = 15'b000000100000000,
		S_PFX_A = 15'b000001000000000,
		S_PFX_B = 15'b000010000000000,
		S_SCT_A = 15'b000100000000000,
		S_SCT_B = 15'b001000000000000,
		S_SCT_C = 15'b010000000000000,
		S_FIN   = 15'b100000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [GRID_W-1:0] gw_q;
	logic [GRID_W-1:0] gh_q;
	logic [CS_W-1:0] cs_q;

	// frame state
	logic [HW-1:0] held_q;
	logic built_q;

	// working registers
	logic [ACT_W-1:0] act_q;
	logic [POS_WIDTH-1:0] py_q;
	logic [QCELL_W-1:0] qc_q;
	logic [GRID_W-1:0] qx_q;
	logic [GRID_W-1:0] qy_q;
	logic [HW-1:0] idx_q;
	logic [CIW-1:0] cidx_q;
	logic [HW-1:0] off_q;
	logic [CIW-1:0] cell_q;

	// result register
	result_t res_q;
	logic done_q;

	// stores, each one write and one read port with registered read
	logic [CIW-1:0] pc_mem [MAX_POINTS];
	logic [HW-1:0] rs_mem [MAX_CELLS];
	logic [HW-1:0] re_mem [MAX_CELLS];
	logic [HW-1:0] wc_mem [MAX_CELLS];
	logic [PIW-1:0] sp_mem [MAX_POINTS];

	logic pc_we, rs_we, re_we, wc_we, sp_we;
	logic [PIW-1:0] pc_wa, pc_ra, sp_wa, sp_ra;
	logic [CIW-1:0] rs_wa, rs_ra, re_wa, re_ra, wc_wa, wc_ra;
	logic [CIW-1:0] pc_wd, pc_rd;
	logic [HW-1:0] rs_wd, re_wd, wc_wd;
	logic [HW-1:0] rs_rd, re_rd, wc_rd;
	logic [PIW-1:0] sp_wd, sp_rd;

	// derived grid values
	logic [GRID_W-1:0] eff_w, eff_h;
	logic [PRW-1:0] grid_prod;
	logic [NW-1:0] ncell;
	logic [CIW-1:0] last_cell;
	logic [PRW-1:0] loc_raw;
	logic [CIW-1:0] loc_cell;
	logic [CIW-1:0] sat_c;

	// divider hookup
	logic div_start;
	logic [POS_WIDTH-1:0] div_num, numx, numy, div_q;
	logic [CS_W-1:0] div_den;
	div_stat_t div_stat;

	logic accept;
	logic room;

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	// take config words only while idle and no command is offered
	assign cfg_ready = !busy && !start;

	// a zero grid size acts as one, the cell count saturates to the store depth
	assign eff_w = (gw_q == '0) ? GRID_W'(1) : gw_q;
	assign eff_h = (gh_q == '0) ? GRID_W'(1) : gh_q;
	assign grid_prod = PRW'(eff_w) * PRW'(eff_h);
	assign ncell = (NW'(grid_prod) > NW'(MAX_CELLS)) ? NW'(MAX_CELLS) : NW'(grid_prod);
	assign last_cell = CIW'(ncell - NW'(1));

	// row-major cell of the added point, saturated to the last cell
	assign loc_raw = PRW'(qy_q) * PRW'(eff_w) + PRW'(qx_q);
	assign loc_cell = (NW'(loc_raw) >= ncell) ? last_cell : CIW'(loc_raw);

	// stale stored cells beyond the current grid fold onto the last cell
	assign sat_c = (NW'(pc_rd) >= ncell) ? last_cell : pc_rd;

	assign room = (held_q < HW'(MAX_POINTS));

	// negative or zero coordinates divide as zero, landing in the first column or row
	assign numx = (!pos_x[POS_WIDTH-1] && (pos_x != '0)) ? pos_x : '0;
	assign numy = (!py_q[POS_WIDTH-1] && (py_q != '0)) ? py_q : '0;
	assign div_num = (state_q == S_IDLE) ? numx : numy;
	assign div_den = (cs_q == '0) ? CS_W'(1) : cs_q;
	assign div_start = (accept && (action == ACT_ADD)) ||
		((state_q == S_DIVX) && div_stat.done);

	ugbs_div #(
		.PW(POS_WIDTH)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.quot(div_q),
		.stat(div_stat)
	);

	function automatic logic [GRID_W-1:0] clamp_axis(input logic [POS_WIDTH-1:0] q,
		input logic [GRID_W-1:0] lim);
		return (q >= POS_WIDTH'(lim)) ? (lim - GRID_W'(1)) : GRID_W'(q);
	endfunction

	function automatic result_t mk_res(input logic [STAT_W-1:0] st,
		input logic [CELL_RES_W-1:0] cr, input logic [RANGE_W-1:0] rs,
		input logic [RANGE_W-1:0] re, input logic [PIDX_W-1:0] pi,
		input logic [COUNT_W-1:0] pc);
		result_t r;
		r.status = st;
		r.cell_res = cr;
		r.range_start = rs;
		r.range_end = re;
		r.point_index = pi;
		r.point_count = pc;
		return r;
	endfunction

	// store port steering per sequencer step
	always_comb begin
		pc_we = 1'b0;
		pc_wa = PIW'(idx_q);
		pc_wd = sat_c;
		pc_ra = PIW'(idx_q);
		rs_we = 1'b0;
		rs_wa = cidx_q;
		rs_wd = off_q;
		rs_ra = CIW'(query_cell);
		re_we = 1'b0;
		re_wa = cidx_q;
		re_wd = '0;
		re_ra = cidx_q;
		wc_we = 1'b0;
		wc_wa = cidx_q;
		wc_wd = off_q;
		wc_ra = pc_rd;
		sp_we = 1'b0;
		sp_wa = PIW'(wc_rd);
		sp_wd = PIW'(idx_q);
		sp_ra = PIW'(query_slot);
		unique case (state_q)
			S_IDLE: begin
				re_ra = CIW'(query_cell);
			end
			S_LOC: begin
				// append the point's cell at the end of the store
				pc_we = room;
				pc_wa = PIW'(held_q);
				pc_wd = loc_cell;
			end
			S_CLR: begin
				re_we = 1'b1;
			end
			S_CNT_B: begin
				pc_we = 1'b1;
				re_ra = sat_c;
			end
			S_CNT_C: begin
				re_we = 1'b1;
				re_wa = cell_q;
				re_wd = re_rd + HW'(1);
			end
			S_PFX_B: begin
				rs_we = 1'b1;
				re_we = 1'b1;
				re_wd = off_q + re_rd;
				wc_we = 1'b1;
			end
			S_SCT_C: begin
				wc_we = 1'b1;
				wc_wa = cell_q;
				wc_wd = wc_rd + HW'(1);
				sp_we = (wc_rd < HW'(MAX_POINTS));
			end
			S_DIVX, S_DIVY, S_QRD, S_CNT_A, S_PFX_A, S_SCT_A, S_SCT_B, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pc_we) begin
			pc_mem[pc_wa] <= pc_wd;
		end
		pc_rd <= pc_mem[pc_ra];
	end

	always_ff @(posedge clk) begin
		if (rs_we) begin
			rs_mem[rs_wa] <= rs_wd;
		end
		rs_rd <= rs_mem[rs_ra];
	end

	always_ff @(posedge clk) begin
		if (re_we) begin
			re_mem[re_wa] <= re_wd;
		end
		re_rd <= re_mem[re_ra];
	end

	always_ff @(posedge clk) begin
		if (wc_we) begin
			wc_mem[wc_wa] <= wc_wd;
		end
		wc_rd <= wc_mem[wc_ra];
	end

	always_ff @(posedge clk) begin
		if (sp_we) begin
			sp_mem[sp_wa] <= sp_wd;
		end
		sp_rd <= sp_mem[sp_ra];
	end

	// payload captured at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			py_q <= pos_y;
			qc_q <= query_cell;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (action)
						ACT_ADD, ACT_BUILD: begin
						end
						ACT_RD_CELL: begin
							if (!built_q) begin
								res_q <= mk_res(ST_NOT_BUILT, query_cell, '0, '0, '0,
									COUNT_W'(held_q));
							end else begin
								res_q <= mk_res(ST_OOR, query_cell, '0, '0, '0,
									COUNT_W'(held_q));
							end
						end
						ACT_RD_SLOT: begin
							res_q <= mk_res(built_q ? ST_OOR : ST_NOT_BUILT, '0, '0, '0, '0,
								COUNT_W'(held_q));
						end
						ACT_CLEAR: begin
							res_q <= mk_res(ST_OK, '0, '0, '0, '0, '0);
						end
						default: begin
							res_q <= mk_res(ST_OOR, '0, '0, '0, '0, COUNT_W'(held_q));
						end
					endcase
				end
			end
			S_QRD: begin
				if (act_q == ACT_RD_CELL) begin
					res_q <= mk_res(ST_OK, qc_q, RANGE_W'(rs_rd), RANGE_W'(re_rd), '0,
						COUNT_W'(held_q));
				end else begin
					res_q <= mk_res(ST_OK, '0, '0, '0, PIDX_W'(sp_rd), COUNT_W'(held_q));
				end
			end
			S_LOC: begin
				if (room) begin
					res_q <= mk_res(ST_OK, CELL_RES_W'(loc_cell), '0, '0, PIDX_W'(held_q),
						COUNT_W'(held_q + HW'(1)));
				end else begin
					res_q <= mk_res(ST_FULL, CELL_RES_W'(loc_cell), '0, '0, '0,
						COUNT_W'(held_q));
				end
			end
			S_FIN: begin
				res_q <= mk_res(ST_OK, '0, '0, '0, '0, COUNT_W'(held_q));
			end
			default: begin
			end
		endcase
	end

	// sequencer: walks add, query and the four build passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gw_q <= GRID_W'(64);
			gh_q <= GRID_W'(64);
			cs_q <= CS_W'(256);
			held_q <= '0;
			built_q <= 1'b0;
			done_q <= 1'b0;
			qx_q <= '0;
			qy_q <= '0;
			idx_q <= '0;
			cidx_q <= '0;
			off_q <= '0;
			cell_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (action)
							ACT_ADD: begin
								state_q <= S_DIVX;
							end
							ACT_BUILD: begin
								cidx_q <= '0;
								state_q <= S_CLR;
							end
							ACT_RD_CELL: begin
								// answer at once unless the range stores must be read
								if (built_q && (NW'(query_cell) < ncell)) begin
									state_q <= S_QRD;
								end else begin
									done_q <= 1'b1;
								end
							end
							ACT_RD_SLOT: begin
								if (built_q && (QW'(query_slot) < QW'(held_q))) begin
									state_q <= S_QRD;
								end else begin
									done_q <= 1'b1;
								end
							end
							ACT_CLEAR: begin
								held_q <= '0;
								built_q <= 1'b0;
								done_q <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_QRD: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DIVX: begin
					if (div_stat.done) begin
						qx_q <= clamp_axis(div_q, eff_w);
						state_q <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (div_stat.done) begin
						qy_q <= clamp_axis(div_q, eff_h);
						state_q <= S_LOC;
					end
				end
				S_LOC: begin
					// drop the point when the store is full
					if (room) begin
						held_q <= held_q + HW'(1);
						built_q <= 1'b0;
					end
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_CLR: begin
					if (cidx_q == last_cell) begin
						cidx_q <= '0;
						idx_q <= '0;
						off_q <= '0;
						state_q <= (held_q == '0) ? S_PFX_A : S_CNT_A;
					end else begin
						cidx_q <= cidx_q + CIW'(1);
					end
				end
				S_CNT_A: begin
					state_q <= S_CNT_B;
				end
				S_CNT_B: begin
					cell_q <= sat_c;
					state_q <= S_CNT_C;
				end
				S_CNT_C: begin
					if (idx_q + HW'(1) == held_q) begin
						state_q <= S_PFX_A;
					end else begin
						idx_q <= idx_q + HW'(1);
						state_q <= S_CNT_A;
					end
				end
				S_PFX_A: begin
					state_q <= S_PFX_B;
				end
				S_PFX_B: begin
					off_q <= off_q + re_rd;
					if (cidx_q == last_cell) begin
						idx_q <= '0;
						state_q <= (held_q == '0) ? S_FIN : S_SCT_A;
					end else begin
						cidx_q <= cidx_q + CIW'(1);
						state_q <= S_PFX_A;
					end
				end
				S_SCT_A: begin
					state_q <= S_SCT_B;
				end
				S_SCT_B: begin
					cell_q <= pc_rd;
					state_q <= S_SCT_C;
				end
				S_SCT_C: begin
					if (idx_q + HW'(1) == held_q) begin
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_q + HW'(1);
						state_q <= S_SCT_A;
					end
				end
				S_FIN: begin
					built_q <= 1'b1;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// config words; a grid change makes the ranges stale
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_GRID_W: begin
						gw_q <= cfg_data[GRID_W-1:0];
						built_q <= 1'b0;
					end
					CFG_GRID_H: begin
						gh_q <= cfg_data[GRID_W-1:0];
						built_q <= 1'b0;
					end
					CFG_CELL_SIZE: begin
						cs_q <= cfg_data[CS_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign done = done_q;
	assign status = res_q.status;
	assign cell_res = res_q.cell_res;
	assign range_start = res_q.range_start;
	assign range_end = res_q.range_end;
	assign point_index = res_q.point_index;
	assign point_count = res_q.point_count;

endmodule

[src/ugbs_checker.sv]
// Port-level checks for the grid binning sort block, bound to the top level.
`include "uniform_grid_binning_sort_top_defines.svh"

module ugbs_checker
	import ugbs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [STAT_W-1:0] status,
	input logic [RANGE_W-1:0] range_start,
	input logic [RANGE_W-1:0] range_end
);

	`UGBS_ASSERT_NEXT(a_accept_resp, clk, arst_n, start && !busy, busy || done, "accepted word neither busy nor answered")
	`UGBS_ASSERT_NOW(a_busy_end, clk, arst_n, $fell(busy), done, "busy dropped without a result")
	`UGBS_ASSERT_NOW(a_err_ranges, clk, arst_n, done && (status != ST_OK), (range_start == '0) && (range_end == '0), "error result carries a range")
	`UGBS_ASSERT_NOW(a_range_order, clk, arst_n, done, range_start <= range_end, "range start past range end")

endmodule

bind uniform_grid_binning_sort_top ugbs_checker u_ugbs_checker (.*);
